// ===== hw/rtl/tps_pkg.sv =====
// shared types and constants of the task priority sorter
package tps_pkg;

   localparam int MAX_TASKS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 32;
   localparam int FRAC_BITS      = 14;
   localparam int KF_BITS        = 15;
   localparam int FIELD_BITS     = 32;
   localparam int LVL_BITS       = 6;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 15;
   localparam int FIFO_DEPTH     = 4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KEY_MODE = 1'b0,
      CSR_K_FACTOR = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] wcet;
      logic [FIELD_BITS-1:0] deadline;
      logic                  last_task;
   } req_type;

   typedef struct packed {
      logic [LVL_BITS-1:0] priority_level;
      logic [LVL_BITS-1:0] task_index;
      logic                last_level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANK_RD,
      ST_RANK_CMP,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT
   } back_state_type;

endpackage

// ===== hw/rtl/tps_ram.sv =====
// generic single-port-write ram with registered read
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/tps_front.sv =====
// front end: masks fields, forms the key and queues keyed tasks
module tps_front import tps_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int KEY_BITS   = VALUE_BITS + FRAC_BITS + 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  req_type             req_data,
   input  logic [1:0]          key_mode,
   input  logic [KF_BITS-1:0]  k_factor,
   output logic                q_valid,
   input  logic                q_pop,
   output logic [KEY_BITS-1:0] q_key,
   output logic                q_last
);
   localparam int PROD_BITS = VALUE_BITS + KF_BITS;
   localparam int PTR_BITS  = $clog2(FIFO_DEPTH);

   // stage 1: multiply
   logic                  s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0] s1_d_ff, s1_c_ff;
   logic [PROD_BITS-1:0]  s1_prod_ff;
   logic [1:0]            s1_mode_ff;
   logic                  s1_last_ff;
   logic [KEY_BITS-1:0]   key_c;

   logic [KEY_BITS:0]     fifo_key_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     cnt_ff, cnt_in;
   logic                  push_acc, fifo_wr;

   // leave room for the multiply stage beat still in flight
   assign req_full    = (cnt_ff + {{PTR_BITS{1'b0}}, s1_valid_ff}) >=
                        (PTR_BITS+1)'(FIFO_DEPTH);
   assign push_acc    = req_push && !req_full;
   assign s1_valid_in = push_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_d_ff    <= VALUE_BITS'(req_data.deadline);
      s1_c_ff    <= VALUE_BITS'(req_data.wcet);
      s1_prod_ff <= PROD_BITS'(k_factor) * PROD_BITS'(VALUE_BITS'(req_data.wcet));
      s1_mode_ff <= key_mode;
      s1_last_ff <= req_data.last_task;
   end

   // key offset so that unsigned order equals signed order
   always_comb begin
      logic [KEY_BITS-1:0] base, sub;
      base = KEY_BITS'(s1_d_ff) << FRAC_BITS;
      sub  = '0;
      if (s1_mode_ff[1]) begin
         sub = KEY_BITS'(s1_prod_ff);
      end else if (s1_mode_ff[0]) begin
         sub = KEY_BITS'(s1_c_ff) << FRAC_BITS;
      end
      key_c = (base - sub) ^ {1'b1, {(KEY_BITS-1){1'b0}}};
   end

   assign fifo_wr   = s1_valid_ff;
   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(fifo_wr);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(q_pop && q_valid);
   assign cnt_in    = cnt_ff + (PTR_BITS+1)'(fifo_wr) - (PTR_BITS+1)'(q_pop && q_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (fifo_wr) begin
         fifo_key_ff[wr_ptr_ff] <= {s1_last_ff, key_c};
      end
   end

   assign q_valid = cnt_ff != '0;
   assign q_key   = fifo_key_ff[rd_ptr_ff][KEY_BITS-1:0];
   assign q_last  = fifo_key_ff[rd_ptr_ff][KEY_BITS];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_BITS+1)'(FIFO_DEPTH)) else $error("key queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !(q_pop && q_valid)) else $error("key queue underflow");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push_acc |=> s1_valid_ff) else $error("accepted beat lost");
`endif
endmodule

// ===== hw/rtl/tps_back.sv =====
// back end: stores keys, ranks each task by a serial count and emits levels
module tps_back import tps_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int KEY_BITS  = VALUE_BITS_DEF + FRAC_BITS + 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  logic [KEY_BITS-1:0] q_key,
   input  logic                q_last,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_data,
   output logic                busy
);
   localparam int IDX_BITS = $clog2(MAX_TASKS);
   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

   back_state_type        st_ff, st_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   i_ff, i_in, j_ff, j_in;
   logic [IDX_BITS-1:0]   rank_ff, rank_in;
   logic [KEY_BITS-1:0]   key_i_ff, key_i_in;
   logic                  out_v_ff, out_v_in;
   rsp_type               out_ff, out_in;

   logic                  kw_en, ow_en;
   logic [IDX_BITS-1:0]   kw_addr, k_raddr, o_raddr;
   logic [KEY_BITS-1:0]   k_rdata;
   logic [IDX_BITS-1:0]   o_rdata;
   logic                  ahead;
   logic                  take;

   tps_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_TASKS)) u_key_ram (
      .clock(clock), .wr_en(kw_en), .wr_addr(kw_addr), .wr_data(q_key),
      .rd_addr(k_raddr), .rd_data(k_rdata));

   // the rank written includes the compare of the final key
   tps_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_TASKS)) u_order_ram (
      .clock(clock), .wr_en(ow_en), .wr_addr(rank_in),
      .wr_data(i_ff[IDX_BITS-1:0]), .rd_addr(o_raddr), .rd_data(o_rdata));

   assign take = q_valid && (st_ff == ST_LOAD);
   // rdata of key ram holds key j read in the previous cycle (j_ff - 1)
   assign ahead = (k_rdata < key_i_ff) ||
                  ((k_rdata == key_i_ff) && ((j_ff - 1'b1) < i_ff));

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_LOAD:      if (take && q_last) st_in = ST_RANK_RD;
         ST_RANK_RD:   st_in = ST_RANK_CMP;
         ST_RANK_CMP:  if (j_ff == cnt_ff) begin
                          st_in = (i_ff + 1'b1 == cnt_ff) ? ST_EMIT_RD : ST_RANK_RD;
                       end
         ST_EMIT_RD:   st_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: st_in = ST_EMIT;
         ST_EMIT:      if (!out_v_ff || rsp_pop) begin
                          st_in = (i_ff + 1'b1 == cnt_ff) ? ST_LOAD : ST_EMIT_RD;
                       end
         default:      st_in = ST_LOAD;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rank_in  = rank_ff;
      key_i_in = key_i_ff;
      out_v_in = out_v_ff && !rsp_pop;
      out_in   = out_ff;
      q_pop    = 1'b0;
      kw_en    = 1'b0;
      kw_addr  = cnt_ff[IDX_BITS-1:0];
      k_raddr  = i_ff[IDX_BITS-1:0];
      ow_en    = 1'b0;
      o_raddr  = i_ff[IDX_BITS-1:0];
      case (st_ff)
         ST_LOAD: begin
            q_pop = take;
            if (take) begin
               // a full set drops the beat but still honors last_task
               if (cnt_ff < CNT_BITS'(MAX_TASKS)) begin
                  kw_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               i_in = '0;
            end
         end
         ST_RANK_RD: begin
            // i-th key arrives next cycle; start j at 0
            k_raddr = i_ff[IDX_BITS-1:0];
            j_in    = '0;
            rank_in = '0;
         end
         ST_RANK_CMP: begin
            if (j_ff == '0) begin
               key_i_in = k_rdata;
            end else if (ahead) begin
               rank_in = rank_ff + 1'b1;
            end
            k_raddr = j_ff[IDX_BITS-1:0];
            j_in    = j_ff + 1'b1;
            if (j_ff == cnt_ff) begin
               ow_en = 1'b1;
               if (ahead && j_ff != '0) begin
                  rank_in = rank_ff + 1'b1;
               end
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 == cnt_ff) begin
                  i_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (!out_v_ff || rsp_pop) begin
               out_v_in = 1'b1;
               out_in.priority_level = LVL_BITS'(i_ff);
               out_in.task_index     = LVL_BITS'(o_rdata);
               out_in.last_level     = (i_ff + 1'b1 == cnt_ff);
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 == cnt_ff) begin
                  cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_LOAD;
         cnt_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         out_v_ff <= out_v_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      rank_ff  <= rank_in;
      key_i_ff <= key_i_in;
      out_ff   <= out_in;
   end

   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;
   assign busy      = (st_ff != ST_LOAD) || out_v_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_TASKS)) else $error("task count out of range");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_pop) |=> (out_v_ff && $stable(out_ff)))
      else $error("result beat changed while stalled");
   a_pop_only_load: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == ST_LOAD) else $error("queue popped while sorting");
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EMIT && st_in == ST_LOAD) |=> cnt_ff == '0)
      else $error("set not cleared after last level");
`endif
endmodule

// ===== hw/rtl/task_priority_sorter.sv =====
// top level of the task priority sorter: csr, front end and back end
//  channel  dir  handshake             payload
//  req      in   req_push / req_full   req_data (wcet, deadline, last_task)
//  rsp      out  rsp_pop / rsp_empty   rsp_data (priority_level, task_index, last_level)
//  csr      in   csr_valid / csr_ready csr_index, csr_data
// an accepted task beat passes the multiply stage and the key queue before it is written to the
// key store; the last one triggers a rank pass (one key ram read and compare per cycle), then the
// levels are emitted in turn. reset clears the counts, queue, state and csr registers; the stores
// need no clearing. req_full rises once the 4-entry key queue plus the multiply stage beat reach 4;
// the sorter pops the queue only in its load state. a stalled result holds on rsp_data until popped.
module task_priority_sorter import tps_pkg::*; #(
   parameter int MAX_TASKS  = MAX_TASKS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  req_type                  req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);
   localparam int KEY_BITS = VALUE_BITS + FRAC_BITS + 5;

   logic [1:0]          key_mode_ff;
   logic [KF_BITS-1:0]  k_factor_ff;
   logic                q_valid, q_pop, q_last, busy;
   logic [KEY_BITS-1:0] q_key;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= '0;
         k_factor_ff <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_KEY_MODE: key_mode_ff <= csr_data[1:0];
            CSR_K_FACTOR: k_factor_ff <= csr_data[KF_BITS-1:0];
            default: ;
         endcase
      end
   end

   tps_front #(.VALUE_BITS(VALUE_BITS), .KEY_BITS(KEY_BITS)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .key_mode(key_mode_ff), .k_factor(k_factor_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_key(q_key), .q_last(q_last));

   tps_back #(.MAX_TASKS(MAX_TASKS), .KEY_BITS(KEY_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_key(q_key), .q_last(q_last), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data), .busy(busy));

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result beat dropped");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> busy) else $error("result shown while idle");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> 32'(rsp_data.priority_level) < MAX_TASKS)
      else $error("level out of range");
`endif
endmodule
